// ----- rtl/cbct_pkg.sv -----
// Package for the client byte counter table.
// Holds the operation and status codes and the slot entry type.
// No dependencies.
package cbct_pkg;

  // Operation codes carried on in_kind.
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // Result status codes carried on out_status.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  // Reset value of the client limit register.
  localparam logic [4:0] MAX_CLIENTS_RST = 5'd16;

  typedef logic [30:0] id_t;
  typedef logic [31:0] bytes_t;

  // One slot of the table as stored in memory.
  typedef struct packed {
    id_t    owner;
    bytes_t tx;
    bytes_t rx;
  } slot_entry_t;

endpackage

// ----- rtl/client_byte_counter_table.sv -----
// Client byte counter table: clear, a zero id and an add that finds the count at its limit are answered
// straight from idle; every other operation runs a slot scan that reads one memory entry per cycle over
// the first min(max_clients,SLOTS) slots until a match, then an EXEC step that updates the matched slot.
// One operation at a time; busy falls as the result word is shown, so the next start is taken then.
// Reset empties the table at once through per-slot valid bits (no clearing pass), zeroes the
// client count and sets max_clients to 16. The receiver cannot stall the result strobe.
module client_byte_counter_table
  import cbct_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // Operation channel.
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   in_kind,
  input  logic [30:0]  in_client_id,
  input  logic [31:0]  in_tx_add,
  input  logic [31:0]  in_rx_add,
  // Result channel.
  output logic         out_valid,
  output logic [1:0]   out_status,
  output logic [3:0]   out_slot_index,
  output logic [31:0]  out_tx_total,
  output logic [31:0]  out_rx_total,
  output logic [4:0]   out_clients_active,
  // Configuration channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  // Storage.
  slot_entry_t          mem [SLOTS];
  slot_entry_t          rd_data_r;
  logic                 vld_q_r;
  logic [SLOTS-1:0]     vld_r, vld_nxt;

  // Control and captured operands.
  logic [1:0]           state_r, state_nxt;
  logic [1:0]           kind_r, kind_nxt;
  id_t                  id_r, id_nxt;
  bytes_t               txa_r, txa_nxt;
  bytes_t               rxa_r, rxa_nxt;
  logic [LW-1:0]        iss_cnt_r, iss_cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pend_addr_r, pend_addr_nxt;
  logic [AW-1:0]        hit_addr_r, hit_addr_nxt;
  slot_entry_t          ent_r, ent_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [4:0]           max_clients_r;

  // Result registers.
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [3:0]           out_slot_r, out_slot_nxt;
  bytes_t               out_tx_r, out_tx_nxt;
  bytes_t               out_rx_r, out_rx_nxt;
  logic [4:0]           out_cnt_r, out_cnt_nxt;

  // Memory port controls.
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;
  slot_entry_t          mem_wdata;

  // Scan helpers.
  logic [LW-1:0]        lim;
  logic [LW-1:0]        max_ext;
  id_t                  target;
  slot_entry_t          rd_eff;
  logic                 hit;
  logic                 accept;
  logic [31:0]          hit_idx32;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Slots searched are the first min(max_clients, SLOTS).
  assign max_ext = LW'(max_clients_r);
  assign lim     = (max_ext < LW'(SLOTS)) ? max_ext : LW'(SLOTS);

  // A slot whose valid bit is clear reads as free with zero counters.
  assign rd_eff    = vld_q_r ? rd_data_r : '0;
  assign target    = (kind_r == KIND_ADD) ? '0 : id_r;
  assign hit       = (state_r == S_SCAN) && pend_r && (rd_eff.owner == target);
  assign rd_addr   = iss_cnt_r[AW-1:0];
  assign rd_en     = (state_r == S_SCAN) && (iss_cnt_r < lim) && !hit;
  assign hit_idx32 = 32'(hit_addr_r);

  // Next-state and result logic. The write-back in EXEC lands as busy
  // falls, so the next scan never reads a stale entry.
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    id_nxt         = id_r;
    txa_nxt        = txa_r;
    rxa_nxt        = rxa_r;
    iss_cnt_nxt    = iss_cnt_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    hit_addr_nxt   = hit_addr_r;
    ent_nxt        = ent_r;
    cnt_nxt        = cnt_r;
    vld_nxt        = vld_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_tx_nxt     = out_tx_r;
    out_rx_nxt     = out_rx_r;
    out_cnt_nxt    = out_cnt_r;
    mem_we         = 1'b0;
    mem_wdata      = ent_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt       = in_kind;
          id_nxt         = in_client_id;
          txa_nxt        = in_tx_add;
          rxa_nxt        = in_rx_add;
          iss_cnt_nxt    = '0;
          out_slot_nxt   = '0;
          out_tx_nxt     = '0;
          out_rx_nxt     = '0;
          out_cnt_nxt    = cnt_r;
          if (in_kind == KIND_CLEAR) begin
            vld_nxt        = '0;
            cnt_nxt        = '0;
            out_cnt_nxt    = '0;
            out_status_nxt = ST_OK;
            out_valid_nxt  = 1'b1;
          end else if (in_client_id == '0) begin
            out_status_nxt = ST_INVALID;
            out_valid_nxt  = 1'b1;
          end else if ((in_kind == KIND_ADD) && (cnt_r >= max_clients_r)) begin
            out_status_nxt = ST_FULL;
            out_valid_nxt  = 1'b1;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle and compare the entry that came back.
        if (rd_en) begin
          iss_cnt_nxt   = iss_cnt_r + LW'(1);
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_addr;
        end
        if (hit) begin
          hit_addr_nxt = pend_addr_r;
          ent_nxt      = rd_eff;
          state_nxt    = S_EXEC;
        end else if (iss_cnt_r >= lim) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = (kind_r == KIND_ADD) ? ST_FULL : ST_NOT_FOUND;
          out_slot_nxt   = '0;
          out_tx_nxt     = '0;
          out_rx_nxt     = '0;
          out_cnt_nxt    = cnt_r;
        end
      end

      S_EXEC: begin
        // Modify the matched slot and write it back; a remove only clears its valid bit.
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_slot_nxt   = hit_idx32[3:0];
        case (kind_r)
          KIND_ADD: begin
            mem_we               = 1'b1;
            mem_wdata.owner      = id_r;
            mem_wdata.tx         = '0;
            mem_wdata.rx         = '0;
            vld_nxt[hit_addr_r]  = 1'b1;
            cnt_nxt              = cnt_r + 5'd1;
          end
          KIND_UPDATE: begin
            mem_we       = 1'b1;
            mem_wdata.tx = ent_r.tx + txa_r;
            mem_wdata.rx = ent_r.rx + rxa_r;
          end
          default: begin
            mem_wdata.tx        = '0;
            mem_wdata.rx        = '0;
            vld_nxt[hit_addr_r] = 1'b0;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - 5'd1;
            end
          end
        endcase
        out_tx_nxt  = mem_wdata.tx;
        out_rx_nxt  = mem_wdata.rx;
        out_cnt_nxt = cnt_nxt;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Slot memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[hit_addr_r] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      vld_q_r   <= vld_r[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pend_r        <= 1'b0;
      vld_r         <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      max_clients_r <= MAX_CLIENTS_RST;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      vld_r       <= vld_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_clients_r <= cfg_data;
      end
    end
  end

  // Operands, scan position and result word.
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    id_r         <= id_nxt;
    txa_r        <= txa_nxt;
    rxa_r        <= rxa_nxt;
    iss_cnt_r    <= iss_cnt_nxt;
    pend_addr_r  <= pend_addr_nxt;
    hit_addr_r   <= hit_addr_nxt;
    ent_r        <= ent_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_tx_r     <= out_tx_nxt;
    out_rx_r     <= out_rx_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot_index     = out_slot_r;
  assign out_tx_total       = out_tx_r;
  assign out_rx_total       = out_rx_r;
  assign out_clients_active = out_cnt_r;

`ifndef SYNTHESIS
  // A match in the scan always leads to the write-back cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    hit |=> (state_r == S_EXEC))
    else $error("scan hit did not reach write-back");

  // The write-back cycle always produces exactly one result and frees the block.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> (out_valid && (state_r == S_IDLE)))
    else $error("write-back did not deliver a result");

  // A successful add raises the client count by one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && kind_r == KIND_ADD) |=>
      (out_clients_active == 5'($past(cnt_r) + 5'd1)))
    else $error("add did not raise the client count");

  // The client count shown with a result never exceeds the number of slots.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_clients_active) <= SLOTS))
    else $error("client count above the number of slots");
`endif

endmodule
